FILE: rtl/scsa_pkg.sv
// Package: widths, constants and controller states of the sensor calibrate block.
`timescale 1ns / 1ps
package scsa_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned DIFF_W   = 17;
  localparam int unsigned MEAN_W   = 20;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WIDE_W   = 10;

  // Default window depth
  localparam int unsigned WINDOW_DEPTH_DEF = 16;

  // Calibration start values
  localparam logic signed [SAMPLE_W-1:0] CAL_LOW_START  = 16'sd32000;
  localparam logic signed [SAMPLE_W-1:0] CAL_HIGH_START = -16'sd32000;

  // Mapping tops
  localparam logic [WIDE_W-1:0] BYTE_TOP = 10'd255;
  localparam logic [WIDE_W-1:0] WIDE_TOP = 10'd1023;

  // Mean divider: quotient bits of sum * 16 / count
  localparam int unsigned MQ_W   = 20;
  // Map divider: quotient bits, dividend width (x - low) * top
  localparam int unsigned MAP_QB = WIDE_W;
  localparam int unsigned NUM_W  = 28;
  localparam int unsigned MAG_W  = NUM_W - 1;
  localparam int unsigned STEP_W = 5;

  // Map lanes
  localparam int unsigned LANES     = 4;
  localparam int unsigned LANE_BYTE = 0;
  localparam int unsigned LANE_WIDE = 1;
  localparam int unsigned LANE_DIFF = 2;
  localparam int unsigned LANE_MEAN = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_MEAN_SETUP,
    ST_MEAN,
    ST_MAP_SETUP,
    ST_MAP,
    ST_FINISH
  } scsa_state_e;

endpackage

FILE: rtl/scsa_if.sv
// Interfaces: sample request channel and result channel.
`timescale 1ns / 1ps
interface scsa_in_if;
  import scsa_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       calibrate;
  logic                       cal_restart;
  logic                       clear_window;

  modport source (
    output valid, sample, calibrate, cal_restart, clear_window,
    input  ready
  );
  modport sink (
    input  valid, sample, calibrate, cal_restart, clear_window,
    output ready
  );
endinterface

interface scsa_out_if;
  import scsa_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [BYTE_W-1:0]          scaled_byte;
  logic [WIDE_W-1:0]          scaled_wide;
  logic signed [DIFF_W-1:0]   difference;
  logic [BYTE_W-1:0]          scaled_difference;
  logic signed [MEAN_W-1:0]   window_mean;
  logic                       mean_valid;
  logic [BYTE_W-1:0]          scaled_mean;
  logic                       scale_valid;
  logic signed [SAMPLE_W-1:0] cal_low;
  logic signed [SAMPLE_W-1:0] cal_high;

  modport source (
    output valid, scaled_byte, scaled_wide, difference, scaled_difference,
           window_mean, mean_valid, scaled_mean, scale_valid, cal_low, cal_high,
    input  ready
  );
  modport sink (
    input  valid, scaled_byte, scaled_wide, difference, scaled_difference,
           window_mean, mean_valid, scaled_mean, scale_valid, cal_low, cal_high,
    output ready
  );
endinterface

FILE: rtl/scsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module scsa_ram #(
  parameter  int unsigned WIDTH  = scsa_pkg::SAMPLE_W,
  parameter  int unsigned DEPTH  = scsa_pkg::WINDOW_DEPTH_DEF,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/sensor_calibrate_scale_average.sv
// Top level: min/max calibration, span mapping and moving-average window.
// One request at a time: the next request is taken in the cycle after the
// result is registered, which waits while the result channel stalls. The
// mean divider takes 20 steps and the span divider 10 steps.
// Reset (rst_ni low, asynchronous) empties the window through the fill count,
// zeroes the samples and sets the calibration range to 32000 / -32000.
`timescale 1ns / 1ps
module sensor_calibrate_scale_average #(
  parameter int unsigned WINDOW_DEPTH = scsa_pkg::WINDOW_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  scsa_in_if.sink    in_i,
  scsa_out_if.source out_o
);
  import scsa_pkg::*;

  localparam int unsigned IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUM_W  = SAMPLE_W + 1 + $clog2(WINDOW_DEPTH);
  localparam int unsigned MREM_W = SUM_W + 4;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW_DEPTH);

  // Controller
  scsa_state_e state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic in_fire, out_load;

  // Item and block state
  logic signed [SAMPLE_W-1:0] smp_q, smp_d;
  logic                       cal_q, cal_d;
  logic signed [SAMPLE_W-1:0] low_q, low_d, high_q, high_d;
  logic signed [SAMPLE_W-1:0] cur_q, cur_d, prev_q, prev_d;
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic [IDX_W-1:0]           idx_q, idx_d;
  logic [CNT_W-1:0]           fill_q, fill_d;

  // Window RAM
  logic                       ram_we;
  logic [SAMPLE_W-1:0]        ram_rdata;
  logic signed [SAMPLE_W-1:0] old_smp;

  // Mean divider
  logic [MREM_W-1:0] mrem_q, mrem_d, mdsh_q, mdsh_d;
  logic [MQ_W-1:0]   mquo_q, mquo_d;
  logic              mneg_q, mneg_d;
  logic              mge;
  logic [SUM_W-1:0]  sum_abs;

  // Map lanes
  logic [MAG_W-1:0]         lrem_q [LANES];
  logic [MAG_W-1:0]         lrem_d [LANES];
  logic [WIDE_W-1:0]        lquo_q [LANES];
  logic [WIDE_W-1:0]        lquo_d [LANES];
  logic [LANES-1:0]         lsat_q, lsat_d, lneg_q, lneg_d, lge;
  logic [MAG_W-1:0]         ldsh_q, ldsh_d;
  logic signed [DIFF_W-1:0] lx [LANES];
  logic signed [DIFF_W:0]   lt [LANES];
  logic signed [NUM_W-1:0]  ln [LANES];
  logic [MAG_W-1:0]         lmag [LANES];
  logic [WIDE_W-1:0]        ltop [LANES];
  logic [WIDE_W-1:0]        lres [LANES];
  logic signed [DIFF_W-1:0] span, diff, mean_int;
  logic [SAMPLE_W-1:0]      span_abs;

  // Result register
  logic                       out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]          o_byte_q, o_byte_d, o_sdiff_q, o_sdiff_d, o_smean_q, o_smean_d;
  logic [WIDE_W-1:0]          o_wide_q, o_wide_d;
  logic signed [DIFF_W-1:0]   o_diff_q, o_diff_d;
  logic signed [MEAN_W-1:0]   o_mean_q, o_mean_d;
  logic                       o_mvalid_q, o_mvalid_d, o_svalid_q, o_svalid_d;
  logic signed [SAMPLE_W-1:0] o_low_q, o_low_d, o_high_q, o_high_d;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_load   = (state_q == ST_FINISH) && (!out_valid_q || out_o.ready);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_READ;
        end
      end
      ST_READ:       state_d = ST_UPDATE;
      ST_UPDATE:     state_d = ST_MEAN_SETUP;
      ST_MEAN_SETUP: state_d = ST_MEAN;
      ST_MEAN: begin
        if (step_q == STEP_W'(MQ_W - 1)) begin
          state_d = ST_MAP_SETUP;
        end
      end
      ST_MAP_SETUP:  state_d = ST_MAP;
      ST_MAP: begin
        if (step_q == STEP_W'(MAP_QB - 1)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default:       state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Window store
  assign ram_we = (state_q == ST_UPDATE) && !cal_q;

  scsa_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (smp_q),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // Slot being replaced reads as zero until the window has filled
  assign old_smp = (fill_q == CNT_FULL) ? $signed(ram_rdata) : '0;

  // Lane operands (span shared by all lanes) and mean divider helpers
  assign span     = DIFF_W'(high_q) - DIFF_W'(low_q);
  assign span_abs = span[DIFF_W-1] ? SAMPLE_W'(-span) : SAMPLE_W'(span);
  assign diff     = DIFF_W'(cur_q) - DIFF_W'(prev_q);
  assign mean_int = mneg_q ? -DIFF_W'({1'b0, mquo_q[MQ_W-1:4]})
                           : DIFF_W'({1'b0, mquo_q[MQ_W-1:4]});
  assign sum_abs  = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign mge      = (mrem_q >= mdsh_q);

  always_comb begin
    lx[LANE_BYTE] = DIFF_W'(cur_q);
    lx[LANE_WIDE] = DIFF_W'(cur_q);
    lx[LANE_DIFF] = diff;
    lx[LANE_MEAN] = mean_int;
    for (int j = 0; j < LANES; j++) begin
      ltop[j] = (j == LANE_WIDE) ? WIDE_TOP : BYTE_TOP;
      lt[j]   = (DIFF_W + 1)'(lx[j]) - (DIFF_W + 1)'(low_q);
      ln[j]   = ((j == LANE_WIDE) ? (NUM_W'(lt[j]) <<< WIDE_W) : (NUM_W'(lt[j]) <<< BYTE_W))
                - NUM_W'(lt[j]);
      lmag[j] = ln[j][NUM_W-1] ? MAG_W'(-ln[j]) : MAG_W'(ln[j]);
      lge[j]  = (lrem_q[j] >= ldsh_q);
      if (lneg_q[j]) begin
        lres[j] = '0;
      end else if (lsat_q[j] || (lquo_q[j] > ltop[j])) begin
        lres[j] = ltop[j];
      end else begin
        lres[j] = lquo_q[j];
      end
    end
  end

  // Datapath next values
  always_comb begin
    step_d      = step_q;
    smp_d       = smp_q;
    cal_d       = cal_q;
    low_d       = low_q;
    high_d      = high_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    sum_d       = sum_q;
    idx_d       = idx_q;
    fill_d      = fill_q;
    mrem_d      = mrem_q;
    mdsh_d      = mdsh_q;
    mquo_d      = mquo_q;
    mneg_d      = mneg_q;
    lrem_d      = lrem_q;
    lquo_d      = lquo_q;
    lsat_d      = lsat_q;
    lneg_d      = lneg_q;
    ldsh_d      = ldsh_q;
    out_valid_d = out_valid_q;
    o_byte_d    = o_byte_q;
    o_wide_d    = o_wide_q;
    o_diff_d    = o_diff_q;
    o_sdiff_d   = o_sdiff_q;
    o_mean_d    = o_mean_q;
    o_mvalid_d  = o_mvalid_q;
    o_smean_d   = o_smean_q;
    o_svalid_d  = o_svalid_q;
    o_low_d     = o_low_q;
    o_high_d    = o_high_q;

    // Take the request; restart calibration, then clear the window
    if (in_fire) begin
      smp_d = in_i.sample;
      cal_d = in_i.calibrate;
      if (in_i.cal_restart) begin
        low_d  = CAL_LOW_START;
        high_d = CAL_HIGH_START;
      end
      if (in_i.clear_window) begin
        sum_d  = '0;
        idx_d  = '0;
        fill_d = '0;
      end
    end

    // Widen the range, or advance the samples and the window
    if (state_q == ST_UPDATE) begin
      if (cal_q) begin
        if (smp_q > high_q) begin
          high_d = smp_q;
        end
        if (smp_q < low_q) begin
          low_d = smp_q;
        end
      end else begin
        prev_d = cur_q;
        cur_d  = smp_q;
        sum_d  = sum_q - SUM_W'(old_smp) + SUM_W'(smp_q);
        idx_d  = (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
        fill_d = (fill_q == CNT_FULL) ? fill_q : fill_q + 1'b1;
      end
    end

    // Load the mean divider with |sum| * 16 over the fill count
    if (state_q == ST_MEAN_SETUP) begin
      mrem_d = {sum_abs, 4'b0000};
      mdsh_d = MREM_W'(fill_q) << (MQ_W - 1);
      mquo_d = '0;
      mneg_d = sum_q[SUM_W-1];
      step_d = '0;
    end

    // One quotient bit per cycle
    if (state_q == ST_MEAN) begin
      if (mge) begin
        mrem_d = mrem_q - mdsh_q;
      end
      mquo_d = {mquo_q[MQ_W-2:0], mge};
      mdsh_d = mdsh_q >> 1;
      step_d = step_q + 1'b1;
    end

    // Load the map lanes; flag quotients that overflow the lane width
    if (state_q == ST_MAP_SETUP) begin
      for (int j = 0; j < LANES; j++) begin
        lrem_d[j] = lmag[j];
        lquo_d[j] = '0;
        lsat_d[j] = (lmag[j] >= (MAG_W'(span_abs) << MAP_QB));
        lneg_d[j] = ln[j][NUM_W-1] ^ span[DIFF_W-1];
      end
      ldsh_d = MAG_W'(span_abs) << (MAP_QB - 1);
      step_d = '0;
    end

    // One quotient bit per cycle in every lane
    if (state_q == ST_MAP) begin
      for (int j = 0; j < LANES; j++) begin
        if (lge[j]) begin
          lrem_d[j] = lrem_q[j] - ldsh_q;
        end
        lquo_d[j] = {lquo_q[j][WIDE_W-2:0], lge[j]};
      end
      ldsh_d = ldsh_q >> 1;
      step_d = step_q + 1'b1;
    end

    // Drop the result once taken, register a new one
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      o_svalid_d  = (low_q != high_q);
      o_mvalid_d  = (fill_q != '0);
      o_byte_d    = o_svalid_d ? lres[LANE_BYTE][BYTE_W-1:0] : '0;
      o_wide_d    = o_svalid_d ? lres[LANE_WIDE] : '0;
      o_sdiff_d   = o_svalid_d ? lres[LANE_DIFF][BYTE_W-1:0] : '0;
      o_smean_d   = (o_svalid_d && o_mvalid_d) ? lres[LANE_MEAN][BYTE_W-1:0] : '0;
      o_diff_d    = diff;
      if (!o_mvalid_d) begin
        o_mean_d = '0;
      end else if (mneg_q) begin
        o_mean_d = -MEAN_W'(mquo_q);
      end else begin
        o_mean_d = MEAN_W'(mquo_q);
      end
      o_low_d     = low_q;
      o_high_d    = high_q;
    end
  end

  // Control and block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      low_q       <= CAL_LOW_START;
      high_q      <= CAL_HIGH_START;
      cur_q       <= '0;
      prev_q      <= '0;
      sum_q       <= '0;
      idx_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      low_q       <= low_d;
      high_q      <= high_d;
      cur_q       <= cur_d;
      prev_q      <= prev_d;
      sum_q       <= sum_d;
      idx_q       <= idx_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and divider registers
  always_ff @(posedge clk_i) begin
    smp_q      <= smp_d;
    cal_q      <= cal_d;
    mrem_q     <= mrem_d;
    mdsh_q     <= mdsh_d;
    mquo_q     <= mquo_d;
    mneg_q     <= mneg_d;
    lrem_q     <= lrem_d;
    lquo_q     <= lquo_d;
    lsat_q     <= lsat_d;
    lneg_q     <= lneg_d;
    ldsh_q     <= ldsh_d;
    o_byte_q   <= o_byte_d;
    o_wide_q   <= o_wide_d;
    o_diff_q   <= o_diff_d;
    o_sdiff_q  <= o_sdiff_d;
    o_mean_q   <= o_mean_d;
    o_mvalid_q <= o_mvalid_d;
    o_smean_q  <= o_smean_d;
    o_svalid_q <= o_svalid_d;
    o_low_q    <= o_low_d;
    o_high_q   <= o_high_d;
  end

  // Result channel
  assign out_o.valid             = out_valid_q;
  assign out_o.scaled_byte       = o_byte_q;
  assign out_o.scaled_wide       = o_wide_q;
  assign out_o.difference        = o_diff_q;
  assign out_o.scaled_difference = o_sdiff_q;
  assign out_o.window_mean       = o_mean_q;
  assign out_o.mean_valid        = o_mvalid_q;
  assign out_o.scaled_mean       = o_smean_q;
  assign out_o.scale_valid       = o_svalid_q;
  assign out_o.cal_low           = o_low_q;
  assign out_o.cal_high          = o_high_q;

endmodule

FILE: tb/sensor_calibrate_scale_average_test.sv
// Testbench: random and directed sensor requests checked against a cycle-free predictor.
`timescale 1ns / 1ps

import scsa_pkg::*;

typedef struct {
  logic signed [SAMPLE_W-1:0] sample;
  logic                       calibrate;
  logic                       cal_restart;
  logic                       clear_window;
} sensor_req_t;

typedef struct {
  logic [BYTE_W-1:0]          scaled_byte;
  logic [WIDE_W-1:0]          scaled_wide;
  logic signed [DIFF_W-1:0]   difference;
  logic [BYTE_W-1:0]          scaled_difference;
  logic signed [MEAN_W-1:0]   window_mean;
  logic                       mean_valid;
  logic [BYTE_W-1:0]          scaled_mean;
  logic                       scale_valid;
  logic signed [SAMPLE_W-1:0] cal_low;
  logic signed [SAMPLE_W-1:0] cal_high;
} sensor_res_t;

// Track calibration range and averaging window, queue the expected results.
class scaled_result_checker;
  logic signed [SAMPLE_W-1:0] ring [WINDOW_DEPTH_DEF];
  longint                     ring_sum;
  int                         ring_idx;
  int                         ring_fill;
  logic signed [SAMPLE_W-1:0] cur_sample;
  logic signed [SAMPLE_W-1:0] prev_sample;
  logic signed [SAMPLE_W-1:0] track_lo;
  logic signed [SAMPLE_W-1:0] track_hi;
  sensor_res_t                pending_results[$];
  int                         mismatch_count;

  function new();
    empty_ring();
    cur_sample     = '0;
    prev_sample    = '0;
    track_lo       = CAL_LOW_START;
    track_hi       = CAL_HIGH_START;
    mismatch_count = 0;
  endfunction

  function void empty_ring();
    foreach (ring[i]) ring[i] = '0;
    ring_sum  = 0;
    ring_idx  = 0;
    ring_fill = 0;
  endfunction

  // Map x from [track_lo, track_hi] onto 0..top, truncate toward zero, clamp.
  function longint map_to_range(longint x, longint top);
    longint span;
    longint v;
    span = longint'(track_hi) - longint'(track_lo);
    if (span == 0) return 0;
    v = (x - longint'(track_lo)) * top / span;
    if (v < 0) v = 0;
    if (v > top) v = top;
    return v;
  endfunction

  function void note_request(sensor_req_t r);
    sensor_res_t want;
    longint      diff;
    longint      mean16;
    longint      mean_int;
    // Restart the range, then clear the window, then the item's own action
    if (r.cal_restart) begin
      track_lo = CAL_LOW_START;
      track_hi = CAL_HIGH_START;
    end
    if (r.clear_window) empty_ring();
    if (r.calibrate) begin
      if (r.sample > track_hi) track_hi = r.sample;
      if (r.sample < track_lo) track_lo = r.sample;
    end else begin
      prev_sample    = cur_sample;
      cur_sample     = r.sample;
      ring_sum       = ring_sum - longint'(ring[ring_idx]) + longint'(r.sample);
      ring[ring_idx] = r.sample;
      ring_idx       = (ring_idx + 1) % WINDOW_DEPTH_DEF;
      if (ring_fill < WINDOW_DEPTH_DEF) ring_fill++;
    end

    diff     = longint'(cur_sample) - longint'(prev_sample);
    mean16   = 0;
    mean_int = 0;
    if (ring_fill != 0) begin
      mean16   = ring_sum * 16 / longint'(ring_fill);
      mean_int = ring_sum / longint'(ring_fill);
    end

    want.scaled_byte       = BYTE_W'(map_to_range(cur_sample, longint'(BYTE_TOP)));
    want.scaled_wide       = WIDE_W'(map_to_range(cur_sample, longint'(WIDE_TOP)));
    want.difference        = diff[DIFF_W-1:0];
    want.scaled_difference = BYTE_W'(map_to_range(diff, longint'(BYTE_TOP)));
    want.window_mean       = mean16[MEAN_W-1:0];
    want.mean_valid        = ring_fill != 0;
    want.scaled_mean       = (ring_fill != 0) ?
                             BYTE_W'(map_to_range(mean_int, longint'(BYTE_TOP))) : '0;
    want.scale_valid       = track_lo != track_hi;
    want.cal_low           = track_lo;
    want.cal_high          = track_hi;
    pending_results.push_back(want);
  endfunction

  function int outstanding();
    return pending_results.size();
  endfunction

  task report(string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  task check_result(sensor_res_t got);
    sensor_res_t want;
    if (pending_results.size() == 0) begin
      report("result with no request outstanding");
      return;
    end
    want = pending_results.pop_front();
    compare_field("scaled_byte", 32'(got.scaled_byte), 32'(want.scaled_byte));
    compare_field("scaled_wide", 32'(got.scaled_wide), 32'(want.scaled_wide));
    compare_field("difference", 32'(got.difference), 32'(want.difference));
    compare_field("scaled_difference", 32'(got.scaled_difference),
                  32'(want.scaled_difference));
    compare_field("window_mean", 32'(got.window_mean), 32'(want.window_mean));
    compare_field("mean_valid", 32'(got.mean_valid), 32'(want.mean_valid));
    compare_field("scaled_mean", 32'(got.scaled_mean), 32'(want.scaled_mean));
    compare_field("scale_valid", 32'(got.scale_valid), 32'(want.scale_valid));
    compare_field("cal_low", 32'(got.cal_low), 32'(want.cal_low));
    compare_field("cal_high", 32'(got.cal_high), 32'(want.cal_high));
  endtask
endclass

module sensor_calibrate_scale_average_test;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 12;
  localparam int TIMEOUT_CYCLES = 2000000;
  localparam int RANDOM_ITEMS   = 1450;
  localparam int SETTLE_CYCLES  = 40;

  logic clk_i = 1'b0;
  logic rst_ni;

  scsa_in_if  req_if ();
  scsa_out_if res_if ();

  sensor_calibrate_scale_average #(
    .WINDOW_DEPTH(WINDOW_DEPTH_DEF)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (res_if)
  );

  scaled_result_checker results = new();

  int          sent       = 0;
  int          burst_left = 0;
  int          band_lo    = -32768;
  int          band_hi    = 32767;
  logic [31:0] stall_pat  = '1;
  int          pat_left   = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Stall the result channel on a rotating pattern, reloaded at random when pat_left runs out
  always @(posedge clk_i) begin
    if (pat_left == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pat <= '1;
        1:       stall_pat <= $urandom;
        2:       stall_pat <= $urandom | $urandom;
        default: stall_pat <= ($urandom & $urandom) | 32'h1;
      endcase
      pat_left <= 64;
    end else begin
      stall_pat <= {stall_pat[0], stall_pat[31:1]};
      pat_left  <= pat_left - 1;
    end
    res_if.ready <= stall_pat[0];
  end

  // Capture each accepted result and check it
  always @(posedge clk_i) begin
    sensor_res_t got;
    if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      got.scaled_byte       = res_if.scaled_byte;
      got.scaled_wide       = res_if.scaled_wide;
      got.difference        = res_if.difference;
      got.scaled_difference = res_if.scaled_difference;
      got.window_mean       = res_if.window_mean;
      got.mean_valid        = res_if.mean_valid;
      got.scaled_mean       = res_if.scaled_mean;
      got.scale_valid       = res_if.scale_valid;
      got.cal_low           = res_if.cal_low;
      got.cal_high          = res_if.cal_high;
      results.check_result(got);
    end
  end

  // End the run if it hangs
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("Mismatches found");
    $finish;
  end

  // Hold valid through bursts; drop it for a random gap when a burst ends
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    gap        = $urandom_range(1, 45);
    req_if.valid <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  task automatic send(logic signed [SAMPLE_W-1:0] s, logic cal, logic restart, logic clear);
    sensor_req_t r;
    r.sample       = s;
    r.calibrate    = cal;
    r.cal_restart  = restart;
    r.clear_window = clear;
    req_if.valid        <= 1'b1;
    req_if.sample       <= s;
    req_if.calibrate    <= cal;
    req_if.cal_restart  <= restart;
    req_if.clear_window <= clear;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    results.note_request(r);
    sent++;
    pace();
  endtask

  // Hold off new requests until every result is back
  task automatic drain();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (results.outstanding() != 0);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] sample_between(int a, int b);
    int v;
    v = a + int'($urandom_range(0, b - a));
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return v[SAMPLE_W-1:0];
  endfunction

  // Mostly inside the calibrated band with a small margin, sometimes anywhere
  function automatic logic signed [SAMPLE_W-1:0] stream_sample();
    int margin;
    margin = (band_hi - band_lo) / 8 + 1;
    if ($urandom_range(0, 4) == 0) return 16'($urandom);
    return sample_between(band_lo - margin, band_hi + margin);
  endfunction

  task automatic pick_band();
    int w;
    band_lo = int'($urandom_range(0, 65535)) - 32768;
    case ($urandom_range(0, 2))
      0:       w = $urandom_range(0, 16);
      1:       w = $urandom_range(17, 4000);
      default: w = $urandom_range(4001, 65535);
    endcase
    band_hi = band_lo + w;
    if (band_hi > 32767) band_hi = 32767;
  endtask

  initial begin
    int  n;
    int  last;
    bit  drained;
    drained = 1'b0;

    rst_ni              <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.sample       <= '0;
    req_if.calibrate    <= 1'b0;
    req_if.cal_restart  <= 1'b0;
    req_if.clear_window <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: range above itself after reset, extremes of sample and difference
    send(16'sd0, 1'b0, 1'b0, 1'b0);
    send(16'sh7FFF, 1'b0, 1'b0, 1'b0);
    send(16'sh8000, 1'b0, 1'b0, 1'b0);
    send(16'sh7FFF, 1'b0, 1'b0, 1'b0);
    // A single calibration sample leaves min equal to max
    send(16'sd100, 1'b1, 1'b1, 1'b0);
    send(16'sd100, 1'b0, 1'b0, 1'b0);
    // Widen to the full range, then clamp checks
    send(16'sh8000, 1'b1, 1'b0, 1'b0);
    send(16'sh7FFF, 1'b1, 1'b0, 1'b0);
    send(16'sd0, 1'b0, 1'b0, 1'b0);
    send(16'sh8000, 1'b0, 1'b0, 1'b0);
    send(16'sh7FFF, 1'b0, 1'b0, 1'b0);
    send(-16'sd1, 1'b0, 1'b0, 1'b0);
    // Calibrate on a freshly cleared window: no mean yet
    send(-16'sd5, 1'b1, 1'b1, 1'b1);
    send(16'sd5, 1'b0, 1'b0, 1'b1);
    // Calibrate at the start values themselves
    send(16'sd32000, 1'b1, 1'b1, 1'b0);
    send(-16'sd32000, 1'b1, 1'b0, 1'b0);
    // Restart on a normal item keeps min above max
    send(16'sd1234, 1'b0, 1'b1, 1'b0);
    send(-16'sd1, 1'b1, 1'b1, 1'b1);
    send(16'sh5555, 1'b0, 1'b0, 1'b0);
    send(16'shAAAA, 1'b0, 1'b0, 1'b0);

    // Random: calibration episodes followed by streams, mixed with noise
    last = sent + RANDOM_ITEMS;
    while (sent < last) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          repeat ($urandom_range(1, 4))
            send(16'($urandom), 1'($urandom), $urandom_range(0, 3) == 0,
                 $urandom_range(0, 3) == 0);
        end
        2, 3: begin
          pick_band();
          n = $urandom_range(1, 8);
          for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0) send(16'($urandom), 1'b1, i == 0, 1'b0);
            else send(sample_between(band_lo, band_hi), 1'b1, i == 0, 1'b0);
          end
        end
        4: begin
          send(stream_sample(), 1'b0, 1'b0, 1'b1);
          repeat ($urandom_range(1, 24)) send(stream_sample(), 1'b0, 1'b0, 1'b0);
        end
        default: begin
          repeat ($urandom_range(1, 40))
            send(stream_sample(), 1'b0, 1'b0, $urandom_range(0, 59) == 0);
        end
      endcase
      if ($urandom_range(0, 49) == 0 || (!drained && sent > last - RANDOM_ITEMS / 2)) begin
        drain();
        drained = 1'b1;
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (results.mismatch_count == 0 && results.outstanding() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/scsa_pkg.sv
rtl/scsa_if.sv
rtl/scsa_ram.sv
rtl/sensor_calibrate_scale_average.sv
tb/sensor_calibrate_scale_average_test.sv
